/* rtl/bcc_pkg.sv */
// Shared types, constants and register indexes for the button click classifier.
package bcc_pkg;

  localparam int NUM_BUTTONS_DEF = 12;
  localparam int PIN_W           = 12;
  localparam int CNT8_W          = 8;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 12;
  localparam int ACT_W           = 4;
  localparam int IN_TDATA_W      = 16;
  localparam int OUT_TDATA_W     = 40;

  localparam logic [CNT8_W-1:0] SAT_MAX = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_POLARITY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = 3'd4;

  localparam logic [CNT8_W-1:0] WINDOW_RST = 8'd20;
  localparam logic [CNT8_W-1:0] SHORT_RST  = 8'd3;
  localparam logic [CNT8_W-1:0] LONG_RST   = 8'd100;
  localparam logic [ACT_W-1:0]  ACTIVE_RST = 4'd12;

  typedef struct packed {
    logic [CNT8_W-1:0] since;
    logic [CNT8_W-1:0] press;
  } bcc_state_t;

  localparam int STATE_W = $bits(bcc_state_t);

  localparam bcc_state_t STATE_RST = '{since: SAT_MAX, press: 8'd0};

  typedef struct packed {
    logic [CNT8_W-1:0] window;
    logic [CNT8_W-1:0] short_ticks;
    logic [CNT8_W-1:0] long_ticks;
  } bcc_cfg_t;

  typedef struct packed {
    logic sclick;
    logic lclick;
    logic dclick;
  } bcc_event_t;

endpackage

/* rtl/bcc_ram.sv */
// Generic single-port-write, registered-read RAM.
module bcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 12,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/bcc_update.sv */
// Per-button counter update and click classification.
module bcc_update
  import bcc_pkg::*;
(
  input  bcc_state_t state_in,
  input  logic       active,
  input  bcc_cfg_t   cfg,
  output bcc_state_t state_out,
  output bcc_event_t evt
);

  logic [CNT8_W-1:0] press;
  logic [CNT8_W-1:0] since;
  logic              is_short;
  logic              is_long;

  always_comb begin
    if (!active) begin
      press = '0;
    end else if (state_in.press == SAT_MAX) begin
      press = SAT_MAX;
    end else begin
      press = state_in.press + 8'd1;
    end
    since = (state_in.since == SAT_MAX) ? SAT_MAX : state_in.since + 8'd1;

    is_long  = (press == cfg.long_ticks);
    is_short = (press == cfg.short_ticks) && !is_long;

    evt.lclick = is_long;
    evt.dclick = is_short && (since <= cfg.window);
    evt.sclick = is_short && (since > cfg.window);

    state_out.press = press;
    state_out.since = evt.sclick ? '0 : since;
  end

endmodule

/* rtl/button_click_classifier_unit.sv */
// Top level of the button click classifier: sequencer, state RAM and result register.
//
//  channel | handshake                  | payload
//  --------+----------------------------+--------------------------------------------
//  in      | s_tvalid / s_tready        | s_tdata[11:0] pin_levels
//  out     | m_tvalid / m_tready        | m_tdata short[11:0] long[23:12] double[35:24]
//  cfg     | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One button per cycle through the state RAM unless the pipeline stalls; the next word
// enters while the last button of the previous one is read.
// A word with no active buttons is taken without issuing any RAM reads and gives no result.
// Reset returns config registers to defaults, clears the valid flags and marks every RAM entry unwritten; no sweep.
// A finished result waits in the output register; the pipeline stalls only when a
// further result is ready while that register is still full.
module button_click_classifier_unit
  import bcc_pkg::*;
#(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [11:0] pin_levels
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [11:0] short, [23:12] long, [35:24] double
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int CNT_W = $clog2(NUM_BUTTONS + 1);

  // configuration
  logic [PIN_W-1:0] polarity;
  bcc_cfg_t         cfg;
  logic [ACT_W-1:0] act_buttons;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      polarity        <= '0;
      cfg.window      <= WINDOW_RST;
      cfg.short_ticks <= SHORT_RST;
      cfg.long_ticks  <= LONG_RST;
      act_buttons     <= ACTIVE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POLARITY: polarity        <= cfg_data[PIN_W-1:0];
        REG_WINDOW:   cfg.window      <= cfg_data[CNT8_W-1:0];
        REG_SHORT:    cfg.short_ticks <= cfg_data[CNT8_W-1:0];
        REG_LONG:     cfg.long_ticks  <= cfg_data[CNT8_W-1:0];
        REG_ACTIVE:   act_buttons     <= cfg_data[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // issue stage
  logic             busy;
  logic [IDX_W-1:0] k;
  logic [CNT_W-1:0] n;
  logic [PIN_W-1:0] levels;
  logic             last_issue;
  logic             stall;
  logic             s_acc;
  logic [4:0]       act5;
  logic [CNT_W-1:0] n_new;
  logic [PIN_W-1:0] k_bit;

  assign act5       = {1'b0, act_buttons};
  assign n_new      = (act5 > 5'(NUM_BUTTONS)) ? CNT_W'(NUM_BUTTONS) : CNT_W'(act5);
  assign last_issue = busy && (CNT_W'(CNT_W'(k) + 1'b1) == n);
  assign s_tready   = !stall && (!busy || last_issue);
  assign s_acc      = s_tvalid && s_tready;
  assign k_bit      = PIN_W'(1) << k;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (s_acc) begin
      busy <= (n_new != '0);
    end else if (last_issue && !stall) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      k      <= '0;
      n      <= n_new;
      levels <= s_tdata[PIN_W-1:0];
    end else if (busy && !stall) begin
      k <= k + 1'b1;
    end
  end

  // state RAM with forwarding of a same-cycle write
  logic             rd_en;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  bcc_state_t       wr_data;
  logic [STATE_W-1:0] rd_data;
  logic             fwd_hit;
  bcc_state_t       fwd_data;
  logic [NUM_BUTTONS-1:0] written;

  assign rd_en = busy && !stall;

  bcc_ram #(
    .WIDTH (STATE_W),
    .DEPTH (NUM_BUTTONS)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (k),
    .rd_data (rd_data)
  );

  // compute stage
  logic             c_valid;
  logic [IDX_W-1:0] c_idx;
  logic             c_first;
  logic             c_last;
  logic             c_active;
  logic [PIN_W-1:0] c_bit;
  bcc_state_t       cur;
  bcc_event_t       evt;
  logic [PIN_W-1:0] acc_s, acc_l, acc_d;
  logic [PIN_W-1:0] res_s, res_l, res_d;
  logic             res_nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (!stall) begin
      c_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      c_idx    <= k;
      c_first  <= (k == '0);
      c_last   <= last_issue;
      c_active <= ((levels & k_bit) != '0) == ((polarity & k_bit) != '0);
      c_bit    <= k_bit;
      fwd_hit  <= rd_en && wr_en && (wr_addr == k);
      fwd_data <= wr_data;
    end
  end

  always_comb begin
    if (fwd_hit) begin
      cur = fwd_data;
    end else if (written[c_idx]) begin
      cur = bcc_state_t'(rd_data);
    end else begin
      cur = STATE_RST;
    end
  end

  bcc_update u_update (
    .state_in  (cur),
    .active    (c_active),
    .cfg       (cfg),
    .state_out (wr_data),
    .evt       (evt)
  );

  assign wr_en   = c_valid && !stall;
  assign wr_addr = c_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  assign res_s  = (c_first ? '0 : acc_s) | (evt.sclick ? c_bit : '0);
  assign res_l  = (c_first ? '0 : acc_l) | (evt.lclick ? c_bit : '0);
  assign res_d  = (c_first ? '0 : acc_d) | (evt.dclick ? c_bit : '0);
  assign res_nz = (res_s | res_l | res_d) != '0;
  assign stall  = c_valid && c_last && res_nz && m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      acc_s <= res_s;
      acc_l <= res_l;
      acc_d <= res_d;
    end
  end

  // result register
  logic             load;
  logic [PIN_W-1:0] out_s, out_l, out_d;

  assign load = wr_en && c_last && res_nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_s <= res_s;
      out_l <= res_l;
      out_d <= res_d;
    end
  end

  assign m_tdata = {4'b0, out_d, out_l, out_s};

  // checks
  a_issue_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (CNT_W'(k) < n))
    else $error("issue index beyond button count");

  a_result_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3*PIN_W-1:0] != '0))
    else $error("empty result presented");

  a_no_accept_in_stall: assert property (@(posedge clk) disable iff (rst)
    stall |-> !s_tready && !wr_en)
    else $error("pipeline moved during stall");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> !$past(load) || !$past(m_tvalid))
    else $error("result overwritten while waiting");

endmodule
